// ===== src/tfm_pkg.sv =====
// Shared types, constants and contour lookup functions for the trapezoid filter mask generator.
// Has no dependencies. The top level and the log2 pipeline import it.
`default_nettype none
package tfm_pkg;

  localparam int CONTOUR_POINTS = 20;
  localparam int LOG_STEPS      = 16;  // fraction bits of the log2 result
  localparam int LOG_STAGES     = LOG_STEPS + 1;
  localparam int DIV_BITS       = 16;  // quotient bits of the contour interpolation
  localparam int MAG_W          = 36;

  localparam logic signed [16:0] DB_FLOOR  = -17'sd51200;
  localparam logic signed [16:0] DB_CEIL   = 17'sd2560;
  localparam logic signed [17:0] DB_REF    = 18'sd15360;
  localparam logic signed [17:0] LAST_GAIN = -18'sd256;

  // contour points: frequency in 1/16 Hz, level in 1/256 dB
  localparam logic [17:0] CONTOUR_FREQ [CONTOUR_POINTS] = '{
    18'd0, 18'd320, 18'd480, 18'd640, 18'd960, 18'd1280, 18'd1600, 18'd3200,
    18'd4800, 18'd6400, 18'd9600, 18'd12800, 18'd16000, 18'd32000, 18'd48000,
    18'd64000, 18'd96000, 18'd128000, 18'd160000, 18'd240000};
  localparam logic [15:0] CONTOUR_DB [CONTOUR_POINTS] = '{
    16'd51200, 16'd25600, 16'd23040, 16'd21760, 16'd19200, 16'd18432, 16'd17408,
    16'd15360, 16'd14592, 16'd14336, 16'd14720, 16'd15104, 16'd15360, 16'd14848,
    16'd13824, 16'd13056, 16'd15360, 16'd17152, 16'd16640, 16'd15616};

  typedef enum logic [2:0] {
    REG_BIN_SPACING,
    REG_LOW_SLOPE,
    REG_HIGH_SLOPE,
    REG_PASSBAND_WIDTH,
    REG_LINEAR_MODE,
    REG_LOUDNESS_ON
  } cfg_reg_t;

  typedef enum logic [1:0] {
    LVL_SKIRT,
    LVL_FLOOR,
    LVL_GAIN,
    LVL_ZERO
  } lvl_code_t;

  typedef struct packed {
    logic [7:0]         bin;
    lvl_code_t          code;
    logic [4:0]         seg;
    logic signed [16:0] slope;
  } ctl_t;

  // upper point of the first segment above cf; 0 when cf is past the table
  function automatic logic [4:0] contour_seg(input logic [19:0] cf);
    logic [4:0] seg;
    seg = 5'd0;
    for (int i = CONTOUR_POINTS - 1; i >= 1; i--) begin
      if (cf < {2'b00, CONTOUR_FREQ[i]}) seg = 5'(i);
    end
    return seg;
  endfunction

  function automatic logic [17:0] seg_f0(input logic [4:0] seg);
    logic [4:0] lo;
    lo = seg - 5'd1;
    return (seg == 5'd0) ? 18'd0 : CONTOUR_FREQ[lo];
  endfunction

  function automatic logic [17:0] seg_df(input logic [4:0] seg);
    logic [4:0] lo;
    lo = seg - 5'd1;
    return (seg == 5'd0) ? 18'd1 : CONTOUR_FREQ[seg] - CONTOUR_FREQ[lo];
  endfunction

  function automatic logic [15:0] seg_c0(input logic [4:0] seg);
    logic [4:0] lo;
    lo = seg - 5'd1;
    return (seg == 5'd0) ? 16'd0 : CONTOUR_DB[lo];
  endfunction

  function automatic logic signed [16:0] seg_dc(input logic [4:0] seg);
    logic [4:0] lo;
    lo = seg - 5'd1;
    return (seg == 5'd0) ? 17'sd0 :
      $signed({1'b0, CONTOUR_DB[seg]}) - $signed({1'b0, CONTOUR_DB[lo]});
  endfunction

endpackage
`default_nettype wire

// ===== src/tfm_log2.sv =====
// Pipelined log2 in Q16: one normalise stage then one squaring stage per fraction bit.
// Depends on tfm_pkg; each stage loads on its own enable from the enclosing pipeline.
`default_nettype none
module tfm_log2
  import tfm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic [LOG_STAGES-1:0] en,
  input  wire logic [30:0]           x,
  output logic      [20:0]           y
);

  logic [30:0]          m  [LOG_STAGES];
  logic [4:0]           p  [LOG_STAGES];
  logic [LOG_STEPS-1:0] fr [LOG_STAGES];

  logic [4:0]  p_next;
  logic [30:0] m_next;

  // leading one position, then normalise to Q30
  always_comb begin
    p_next = 5'd0;
    for (int i = 1; i <= 30; i++) begin
      if (x[i]) p_next = 5'(i);
    end
    m_next = x << (5'd30 - p_next);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m[0]  <= m_next;
      p[0]  <= p_next;
      fr[0] <= '0;
    end
  end

  for (genvar k = 1; k < LOG_STAGES; k++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] ms;
    assign sq = m[k-1] * m[k-1];
    assign ms = sq[61:30];
    always_ff @(posedge clk) begin
      if (en[k]) begin
        p[k] <= p[k-1];
        if (ms[31]) begin
          m[k]  <= ms[31:1];
          fr[k] <= {fr[k-1][LOG_STEPS-2:0], 1'b1};
        end else begin
          m[k]  <= ms[30:0];
          fr[k] <= {fr[k-1][LOG_STEPS-2:0], 1'b0};
        end
      end
    end
  end

  assign y = {p[LOG_STAGES-1], fr[LOG_STAGES-1]};

endmodule
`default_nettype wire

// ===== src/trapezoid_filter_mask_gen.sv =====
// Top level of the trapezoid filter mask generator: configuration registers and a 21-stage pipeline.
// Depends on tfm_pkg and tfm_log2.
//
// Usage:
//   Slave stream s_*: one transfer per bin; tdata carries the centre frequency and bin index.
//   Master stream m_*: one transfer per input, the level in 1/256 dB and the echoed bin index.
//   Configuration: cfg_we with cfg_index/cfg_data writes one register per cycle; write only
//   while no transfer is in flight.
// Throughput: one bin per clock, sustained while m_tready stays high. The pipeline depth is set by
//   the 16-step squaring log2 and the matching one-bit-a-stage contour interpolation divider
//   running alongside it.
// Stages: 0 bin frequency and contour segment; 1 passband edges, side and special cases,
//   interpolation product; 2 log2 normalise and divider set-up; 3..18 log2 squarings and
//   quotient bits; 19 octave distance times slope and contour gain; 20 round, add, clamp.
// Reset: empties the pipeline and loads the register reset values.
// Stall: each stage holds while its successor is full and stalled; bubbles still close up,
//   so input transfers continue until every stage holds an item.
`default_nettype none
module trapezoid_filter_mask_gen
  import tfm_pkg::*;
#(
  parameter int NUM_BINS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [19:0] center_freq, [27:20] bin_index
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // [16:0] level_db, [24:17] bin_echo
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);

  localparam int NS = 21;
  localparam int LOG_FIRST = 2;

  // configuration
  logic [19:0]        bin_spacing;
  logic signed [16:0] low_slope;
  logic signed [16:0] high_slope;
  logic [19:0]        passband_width;
  logic               linear_mode;
  logic               loudness_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_spacing    <= 20'd500;
      low_slope      <= DB_FLOOR;
      high_slope     <= DB_FLOOR;
      passband_width <= '0;
      linear_mode    <= 1'b0;
      loudness_on    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BIN_SPACING:    bin_spacing    <= cfg_data;
        REG_LOW_SLOPE:      low_slope      <= $signed(cfg_data[16:0]);
        REG_HIGH_SLOPE:     high_slope     <= $signed(cfg_data[16:0]);
        REG_PASSBAND_WIDTH: passband_width <= cfg_data;
        REG_LINEAR_MODE:    linear_mode    <= cfg_data[0];
        REG_LOUDNESS_ON:    loudness_on    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage valid bits and per-stage advance
  logic [NS-1:0] v;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = m_tready;
    for (int k = NS - 1; k >= 0; k--) en[k] = !v[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= s_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  assign s_tready = en[0];

  // stage 0: bin frequency in 1/32 Hz and contour segment
  logic [19:0] cf0;
  logic [7:0]  bin0;
  logic [29:0] f0;
  logic [4:0]  seg0;
  logic [28:0] fprod;

  assign fprod = s_tdata[27:20] * bin_spacing;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cf0  <= s_tdata[19:0];
      bin0 <= s_tdata[27:20];
      f0   <= {fprod, 1'b0};
      seg0 <= contour_seg(s_tdata[19:0]);
    end
  end

  // stage 1: passband edges, side selection, special cases, interpolation product
  logic signed [22:0] lo;
  logic [21:0]        hi;
  logic               lo_side;
  logic               hi_side;
  logic [30:0]        a_next;
  logic [30:0]        b_next;
  ctl_t               ctl_next;
  logic [19:0]        cf_off;
  logic signed [34:0] n_next;

  always_comb begin
    lo = $signed({2'b00, cf0, 1'b0}) -
         (linear_mode ? $signed({3'b000, passband_width}) : 23'sd0);
    hi = {1'b0, cf0, 1'b0} + (linear_mode ? {2'b00, passband_width} : 22'd0);
    lo_side = $signed({2'b00, f0}) <= $signed({{9{lo[22]}}, lo});
    hi_side = f0 >= {8'd0, hi};
    ctl_next.bin = bin0;
    ctl_next.seg = seg0;
    a_next = '0;
    b_next = '0;
    ctl_next.slope = high_slope;
    ctl_next.code  = LVL_ZERO;
    if (hi_side) begin
      a_next = {1'b0, f0};
      b_next = {9'd0, hi};
      ctl_next.slope = high_slope;
    end else if (lo_side) begin
      a_next = {9'd0, lo[21:0]};
      b_next = {1'b0, f0};
      ctl_next.slope = low_slope;
    end
    if (hi_side || lo_side) begin
      if (ctl_next.slope <= DB_FLOOR) ctl_next.code = LVL_FLOOR;
      else if (a_next == b_next)      ctl_next.code = LVL_GAIN;
      else if (b_next == 31'd0)       ctl_next.code = LVL_FLOOR;
      else                            ctl_next.code = LVL_SKIRT;
    end
    if ({24'd0, bin0} >= NUM_BINS) ctl_next.code = LVL_FLOOR;
    cf_off = cf0 - {2'b00, seg_f0(seg0)};
    n_next = seg_dc(seg0) * $signed({1'b0, cf_off[16:0]});
  end

  ctl_t               ctl [1:NS-1];
  logic [30:0]        a1;
  logic [30:0]        b1;
  logic signed [34:0] n1;
  logic [17:0]        df1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ctl[1] <= ctl_next;
      a1     <= a_next;
      b1     <= b_next;
      n1     <= n_next;
      df1    <= seg_df(seg0);
    end
  end

  for (genvar k = 2; k < NS; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (en[k]) ctl[k] <= ctl[k-1];
    end
  end

  // stages 2..18: two log2 pipelines
  logic [20:0] la;
  logic [20:0] lb;

  tfm_log2 u_log_a (
    .clk (clk),
    .en  (en[LOG_FIRST +: LOG_STAGES]),
    .x   (a1),
    .y   (la)
  );

  tfm_log2 u_log_b (
    .clk (clk),
    .en  (en[LOG_FIRST +: LOG_STAGES]),
    .x   (b1),
    .y   (lb)
  );

  // stage 2: divider set-up for the rounded interpolation n/df
  logic [36:0] num;
  logic [36:0] mag;
  logic [18:0] den_in;

  always_comb begin
    den_in = {df1, 1'b0};
    num    = {n1[34], n1, 1'b0} + {19'd0, df1};
    // negative numerator: floor division via ceiling of the magnitude
    mag    = num[36] ? (37'd0 - num + {18'd0, den_in} - 37'd1) : num;
  end

  logic [MAG_W-1:0]    rem [DIV_BITS+1];
  logic [DIV_BITS-1:0] qt  [DIV_BITS+1];
  logic [18:0]         den [DIV_BITS+1];
  logic                dneg[DIV_BITS+1];

  always_ff @(posedge clk) begin
    if (en[LOG_FIRST]) begin
      rem[0]  <= mag[MAG_W-1:0];
      qt[0]   <= '0;
      den[0]  <= den_in;
      dneg[0] <= num[36];
    end
  end

  // stages 3..18: one quotient bit a stage, most significant first
  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    logic [MAG_W-1:0] cmp;
    assign cmp = {{(MAG_W-19){1'b0}}, den[j]} << (DIV_BITS - 1 - j);
    always_ff @(posedge clk) begin
      if (en[LOG_FIRST+1+j]) begin
        den[j+1]  <= den[j];
        dneg[j+1] <= dneg[j];
        if (rem[j] >= cmp) begin
          rem[j+1] <= rem[j] - cmp;
          qt[j+1]  <= qt[j] | (DIV_BITS'(1) << (DIV_BITS - 1 - j));
        end else begin
          rem[j+1] <= rem[j];
          qt[j+1]  <= qt[j];
        end
      end
    end
  end

  // stage 19: octave distance times slope, contour gain
  localparam int S19 = LOG_FIRST + LOG_STAGES;
  logic signed [21:0] oct_dist;
  logic signed [16:0] qs;
  logic signed [17:0] gain_next;
  logic signed [38:0] prod;
  logic signed [17:0] gain;

  always_comb begin
    oct_dist = $signed({1'b0, la}) - $signed({1'b0, lb});
    qs   = dneg[DIV_BITS] ? -$signed({1'b0, qt[DIV_BITS]}) : $signed({1'b0, qt[DIV_BITS]});
    gain_next = DB_REF - $signed({2'b00, seg_c0(ctl[S19-1].seg)}) - 18'(qs);
    if (ctl[S19-1].seg == 5'd0) gain_next = LAST_GAIN;
    if (!loudness_on)           gain_next = 18'sd0;
  end

  always_ff @(posedge clk) begin
    if (en[S19]) begin
      prod <= oct_dist * ctl[S19-1].slope;
      gain <= gain_next;
    end
  end

  // stage 20: round, add gain, select special cases, clamp
  logic signed [38:0] prod_rnd;
  logic signed [23:0] lvl;
  logic signed [16:0] lvl_sat;
  logic signed [16:0] level_q;

  always_comb begin
    prod_rnd = prod + 39'sd32768;
    case (ctl[NS-2].code)
      LVL_SKIRT: lvl = 24'(gain) + 24'($signed(prod_rnd[38:16]));
      LVL_FLOOR: lvl = 24'(DB_FLOOR);
      LVL_GAIN:  lvl = 24'(gain);
      LVL_ZERO:  lvl = 24'sd0;
      default:   lvl = 24'(DB_FLOOR);
    endcase
    if (lvl < 24'(DB_FLOOR))     lvl_sat = DB_FLOOR;
    else if (lvl > 24'(DB_CEIL)) lvl_sat = DB_CEIL;
    else                         lvl_sat = lvl[16:0];
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) level_q <= lvl_sat;
  end

  assign m_tvalid = v[NS-1];
  assign m_tdata  = {7'd0, ctl[NS-1].bin, level_q};

  // a stalled result holds its level
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(level_q))
    else $error("result changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> level_q >= DB_FLOOR && level_q <= DB_CEIL)
    else $error("level outside saturation range");

  a_beyond: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ({24'd0, ctl[NS-1].bin} >= NUM_BINS) |-> level_q == DB_FLOOR)
    else $error("bin beyond mask not floored");

  a_bubble: assert property (@(posedge clk) disable iff (rst)
    !v[NS-1] |-> s_tready || v[0])
    else $error("pipeline stalled with empty output stage");

endmodule
`default_nettype wire
